@@ hdl/ultrasonic_echo_ranger_assert.svh @@
// Assertion macros for the ultrasonic echo ranger checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// Same-cycle implication, quiet while reset is held
`define UER_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is held
`define UER_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/uer_pkg.sv @@
// Package for the ultrasonic echo ranger: phase type, register map,
// reset values and the width-to-distance conversion. No dependencies.
package uer_pkg;

    // Field and register widths
    localparam int TRIG_W  = 10;
    localparam int TMO_W   = 16;
    localparam int PAUSE_W = 16;
    localparam int CNT_W   = 17;
    localparam int WIDTH_W = 16;
    localparam int DIST_W  = 14;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_TRIGGER = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_PAUSE   = 2'd2;

    // Register reset values
    localparam logic [TRIG_W-1:0]  TRIG_RST  = 10'd10;
    localparam logic [TMO_W-1:0]   TMO_RST   = 16'd30000;
    localparam logic [PAUSE_W-1:0] PAUSE_RST = 16'd60000;

    // Measurement cycle phases
    typedef enum logic [1:0] {
        PH_TRIGGER   = 2'd0,
        PH_WAIT_RISE = 2'd1,
        PH_MEASURE   = 2'd2,
        PH_PAUSE     = 2'd3
    } t_phase;

    // floor(y / 29) for y below 2^19 as (y * DIV_MUL) >> DIV_SHIFT
    localparam int          DIV_SHIFT = 24;
    localparam logic [19:0] DIV_MUL   = 20'd578525;

    // Distance in tenths of a cm: (10*w + 29) / 58, halved first, then / 29
    function automatic logic [DIST_W-1:0] dist_from_width(input logic [WIDTH_W-1:0] w);
        logic [19:0] num;
        logic [18:0] half;
        logic [38:0] prod;
        num  = ({4'd0, w} << 3) + ({4'd0, w} << 1) + 20'd29;
        half = num[19:1];
        prod = {20'd0, half} * {19'd0, DIV_MUL};
        return prod[DIV_SHIFT+DIST_W-1:DIV_SHIFT];
    endfunction

endpackage

@@ hdl/ultrasonic_echo_ranger.sv @@
// Ultrasonic echo ranger top level: phase sequencer, tick counter,
// register port and output register. Depends on uer_pkg.
//
// Use: feed one word per microsecond tick on the input channel
// (i_in_valid / o_in_stall, payload i_echo_level). Every accepted word
// yields exactly one result word on the output channel (o_out_valid /
// i_out_stall) carrying the trigger level for that tick and, on the tick
// a measurement ends, measure_done with no_echo, echo width in us and
// distance in tenths of a cm.
// The result of a word is registered when the word is accepted and shows in the next cycle.
// Throughput: one word per cycle unless a result is held under stall; the
// phase and count update and the constant-reciprocal divide sit between the
// phase registers and the output register, so nothing iterates.
// Stall: while a result waits under i_out_stall the output register holds
// and o_in_stall rises; a waiting result is taken and a new word accepted
// in the same cycle once the stall drops.
// Reset (synchronous, active low): phase returns to trigger with a zero
// count, registers take their defaults, the output register empties.
// Registers sit at byte addresses 0, 4 and 8 and must be written by the user only
// while the block is idle; the block itself does not enforce this.
module ultrasonic_echo_ranger
    import uer_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_echo_level,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_trigger_level,
    output logic                o_measure_done,
    output logic                o_no_echo,
    output logic [WIDTH_W-1:0]  o_echo_width_us,
    output logic [DIST_W-1:0]   o_distance_tenths_cm,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    logic [TRIG_W-1:0]  r_trig_ticks;
    logic [TMO_W-1:0]   r_tmo_ticks;
    logic [PAUSE_W-1:0] r_pause_ticks;

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_count, n_count;

    logic               r_out_valid, n_out_valid;
    logic               r_trig, n_trig;
    logic               r_done, n_done;
    logic               r_none, n_none;
    logic [WIDTH_W-1:0] r_width, n_width;
    logic [DIST_W-1:0]  r_dist, n_dist;

    logic               in_acc;
    logic               cfg_wr;
    logic [1:0]         cfg_idx;
    logic [CNT_W-1:0]   cnt_inc;
    logic [CNT_W-1:0]   trig_len;
    logic               inc_over_tmo;
    logic               tmo_zero;
    logic               finish;
    logic               fail;

    // Register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_ticks  <= TRIG_RST;
            r_tmo_ticks   <= TMO_RST;
            r_pause_ticks <= PAUSE_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_TRIGGER: r_trig_ticks  <= pwdata[TRIG_W-1:0];
                REG_TIMEOUT: r_tmo_ticks   <= pwdata[TMO_W-1:0];
                REG_PAUSE:   r_pause_ticks <= pwdata[PAUSE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_TRIGGER: prdata = {{(DATA_W-TRIG_W){1'b0}}, r_trig_ticks};
            REG_TIMEOUT: prdata = {{(DATA_W-TMO_W){1'b0}}, r_tmo_ticks};
            REG_PAUSE:   prdata = {{(DATA_W-PAUSE_W){1'b0}}, r_pause_ticks};
            default:     prdata = '0;
        endcase
    end

    // Handshake: take a word unless a result is held under stall
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Shared counter terms
    assign cnt_inc      = r_count + 1'b1;
    assign inc_over_tmo = cnt_inc > {1'b0, r_tmo_ticks};
    assign tmo_zero     = (r_tmo_ticks == '0);
    assign trig_len     = (r_trig_ticks == '0) ? CNT_W'(1)
                                               : {{(CNT_W-TRIG_W){1'b0}}, r_trig_ticks};

    // Decide whether this tick ends the measurement, and how
    always_comb begin
        finish = 1'b0;
        fail   = 1'b0;
        case (r_phase)
            PH_WAIT_RISE: begin
                finish = i_echo_level ? tmo_zero : inc_over_tmo;
                fail   = finish;
            end
            PH_MEASURE: begin
                finish = !i_echo_level || inc_over_tmo;
                fail   = i_echo_level;
            end
            default: ;
        endcase
    end

    // Next phase and count
    always_comb begin
        n_phase = r_phase;
        n_count = cnt_inc;
        if (finish) begin
            n_phase = (r_pause_ticks == '0) ? PH_TRIGGER : PH_PAUSE;
            n_count = '0;
        end else begin
            case (r_phase)
                PH_WAIT_RISE: begin
                    if (i_echo_level) begin
                        n_phase = PH_MEASURE;
                        n_count = CNT_W'(1);
                    end
                end
                PH_MEASURE: ;
                PH_PAUSE: begin
                    if (cnt_inc >= {1'b0, r_pause_ticks}) begin
                        n_phase = PH_TRIGGER;
                        n_count = '0;
                    end
                end
                default: begin
                    if (cnt_inc >= trig_len) begin
                        n_phase = PH_WAIT_RISE;
                        n_count = '0;
                    end
                end
            endcase
        end
    end

    // Result word for this tick
    always_comb begin
        n_trig  = (r_phase == PH_TRIGGER);
        n_done  = finish;
        n_width = '0;
        if (finish && !fail) begin
            n_width = r_count[WIDTH_W-1:0];
        end
        n_none  = finish && (n_width == '0);
        n_dist  = (n_width == '0) ? '0 : dist_from_width(n_width);
    end

    // Output register: load on accept, drop once taken
    always_comb begin
        if (in_acc) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TRIGGER;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_acc) begin
                r_phase <= n_phase;
                r_count <= n_count;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_trig  <= n_trig;
            r_done  <= n_done;
            r_none  <= n_none;
            r_width <= n_width;
            r_dist  <= n_dist;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_trigger_level      = r_trig;
    assign o_measure_done       = r_done;
    assign o_no_echo            = r_none;
    assign o_echo_width_us      = r_width;
    assign o_distance_tenths_cm = r_dist;

endmodule

@@ hdl/uer_checker.sv @@
// Port-level checker for the ultrasonic echo ranger, bound to the top level.
// Depends on uer_pkg and ultrasonic_echo_ranger_assert.svh.
`include "ultrasonic_echo_ranger_assert.svh"

module uer_checker
    import uer_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic                o_trigger_level,
    input logic                o_measure_done,
    input logic                o_no_echo,
    input logic [WIDTH_W-1:0]  o_echo_width_us,
    input logic [DIST_W-1:0]   o_distance_tenths_cm
);

    // A held result word keeps its done flag, width and distance
    `UER_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_measure_done) && $stable(o_echo_width_us)
        && $stable(o_distance_tenths_cm), "result word changed under stall")

    // Input stall only while a result is waiting
    `UER_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall,
        "input stalled without a waiting result")

    // Outside a done tick the measurement fields stay clear
    `UER_ASSERT_NOW(a_idle_clear, o_out_valid && !o_measure_done,
        !o_no_echo && o_echo_width_us == '0 && o_distance_tenths_cm == '0,
        "measurement fields set without done")

    // No echo means zero width and distance; an echo has a width
    `UER_ASSERT_NOW(a_none_clear, o_out_valid && o_measure_done,
        (o_no_echo == (o_echo_width_us == '0)) && (!o_no_echo || o_distance_tenths_cm == '0),
        "no_echo disagrees with width")

    // Trigger and done never share a tick
    `UER_ASSERT_NOW(a_trig_done, o_out_valid && o_trigger_level, !o_measure_done,
        "trigger high on a done tick")

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);

@@ dv/echo_ranger_checker.sv @@
`timescale 1ns / 100ps
// Checker for the ultrasonic echo ranger: follows the measurement cycle for every
// accepted tick word and compares each result word, in order, field by field.
// Depends on uer_pkg for widths, phases, register indexes and reset values.
module echo_ranger_checker
    import uer_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_echo_level,
    // output channel
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_trigger_level,
    input  logic               i_measure_done,
    input  logic               i_no_echo,
    input  logic [WIDTH_W-1:0] i_echo_width_us,
    input  logic [DIST_W-1:0]  i_distance_tenths_cm,
    // register port
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [ADDR_W-1:0]  i_paddr,
    input  logic [DATA_W-1:0]  i_pwdata,
    // running totals for the top
    output int                 o_mismatches,
    output int                 o_pending,
    output int                 o_ticks,
    output int                 o_measures,
    output int                 o_misses,
    output int                 o_widest
);

    typedef struct packed {
        logic               trigger;
        logic               done;
        logic               miss;
        logic [WIDTH_W-1:0] width_us;
        logic [DIST_W-1:0]  dist_tenths;
    } t_tick_word;

    // Register copies and cycle state
    logic [TRIG_W-1:0]  trig_ticks;
    logic [TMO_W-1:0]   tmo_ticks;
    logic [PAUSE_W-1:0] pause_len;
    t_phase             phase;
    logic [CNT_W-1:0]   ticks;

    t_tick_word tick_words[$];
    int mismatches;
    int n_ticks;
    int n_measures;
    int n_misses;
    int widest;

    // End a cycle: report the width or a miss, then go to pause or straight to trigger
    function automatic t_tick_word close_cycle(input logic timed_out);
        logic [WIDTH_W-1:0] w;
        t_tick_word         r;
        w = timed_out ? '0 : ticks[WIDTH_W-1:0];
        r = '0;
        r.done = 1'b1;
        r.miss = (w == '0);
        if (!r.miss) begin
            r.width_us    = w;
            r.dist_tenths = DIST_W'((10 * int'(w) + 29) / 58);
        end
        phase = (pause_len == '0) ? PH_TRIGGER : PH_PAUSE;
        ticks = '0;
        return r;
    endfunction

    // Advance the cycle by one tick and return the word it should produce
    function automatic t_tick_word next_tick_word(input logic echo);
        t_tick_word       r;
        logic [CNT_W-1:0] trig_len;
        r = '0;
        trig_len = (trig_ticks == '0) ? CNT_W'(1) : CNT_W'(trig_ticks);
        case (phase)
            PH_WAIT_RISE: begin
                if (echo) begin
                    ticks = CNT_W'(1);
                    if (ticks > CNT_W'(tmo_ticks))
                        r = close_cycle(1'b1);
                    else
                        phase = PH_MEASURE;
                end else begin
                    ticks = ticks + 1'b1;
                    if (ticks > CNT_W'(tmo_ticks))
                        r = close_cycle(1'b1);
                end
            end
            PH_MEASURE: begin
                if (echo) begin
                    ticks = ticks + 1'b1;
                    if (ticks > CNT_W'(tmo_ticks))
                        r = close_cycle(1'b1);
                end else begin
                    r = close_cycle(1'b0);
                end
            end
            PH_PAUSE: begin
                ticks = ticks + 1'b1;
                if (ticks >= CNT_W'(pause_len)) begin
                    phase = PH_TRIGGER;
                    ticks = '0;
                end
            end
            default: begin
                r.trigger = 1'b1;
                ticks = ticks + 1'b1;
                if (ticks >= trig_len) begin
                    phase = PH_WAIT_RISE;
                    ticks = '0;
                end
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(input string fname, input int unsigned want_v,
                                 input int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", fname, want_v, got_v);
            mismatches++;
        end
    endtask

    // Track register writes, retire result words, queue the word each tick should give
    always @(posedge i_clk) begin : track
        t_tick_word got;
        t_tick_word want;
        if (!i_rst_n) begin
            trig_ticks = TRIG_RST;
            tmo_ticks  = TMO_RST;
            pause_len  = PAUSE_RST;
            phase      = PH_TRIGGER;
            ticks      = '0;
            tick_words.delete();
            mismatches = 0;
            n_ticks    = 0;
            n_measures = 0;
            n_misses   = 0;
            widest     = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_TRIGGER: trig_ticks = i_pwdata[TRIG_W-1:0];
                    REG_TIMEOUT: tmo_ticks  = i_pwdata[TMO_W-1:0];
                    REG_PAUSE:   pause_len  = i_pwdata[PAUSE_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got.trigger     = i_trigger_level;
                got.done        = i_measure_done;
                got.miss        = i_no_echo;
                got.width_us    = i_echo_width_us;
                got.dist_tenths = i_distance_tenths_cm;
                if (tick_words.size() == 0) begin
                    $error("result word arrived with no tick word outstanding");
                    mismatches++;
                end else begin
                    want = tick_words.pop_front();
                    compare_field("trigger_level", want.trigger, got.trigger);
                    compare_field("measure_done", want.done, got.done);
                    compare_field("no_echo", want.miss, got.miss);
                    compare_field("echo_width_us", want.width_us, got.width_us);
                    compare_field("distance_tenths_cm", want.dist_tenths, got.dist_tenths);
                    n_ticks++;
                    if (want.done)
                        n_measures++;
                    if (want.done && want.miss)
                        n_misses++;
                    if (int'(want.width_us) > widest)
                        widest = int'(want.width_us);
                end
            end
            if (i_in_valid && !i_in_stall)
                tick_words.push_back(next_tick_word(i_echo_level));
        end
        o_mismatches <= mismatches;
        o_pending    <= tick_words.size();
        o_ticks      <= n_ticks;
        o_measures   <= n_measures;
        o_misses     <= n_misses;
        o_widest     <= widest;
    end

endmodule

@@ dv/tb_ultrasonic_echo_ranger.sv @@
`timescale 1ns / 100ps
// Top of the ultrasonic echo ranger testbench: clock, reset, echo stimulus,
// register writes and receiver stalls; the verdict comes from echo_ranger_checker.
// Depends on uer_pkg, ultrasonic_echo_ranger and echo_ranger_checker.
module tb_ultrasonic_echo_ranger;
    import uer_pkg::*;

    localparam int         WD_LIMIT     = 500;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;
    localparam int         RX_FREE      = 0;
    localparam int         RX_CHOPPY    = 1;
    localparam int         RX_HEAVY     = 2;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                i_echo_level = 1'b0;
    logic                i_out_stall  = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [ADDR_W-1:0]   paddr        = '0;
    logic [DATA_W-1:0]   pwdata       = '0;

    logic                o_in_stall;
    logic                o_out_valid;
    logic                o_trigger_level;
    logic                o_measure_done;
    logic                o_no_echo;
    logic [WIDTH_W-1:0]  o_echo_width_us;
    logic [DIST_W-1:0]   o_distance_tenths_cm;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int n_mismatches;
    int n_pending;
    int n_ticks;
    int n_measures;
    int n_misses;
    int n_widest;

    // Sender pacing and receiver stall state
    logic        pacing     = 1'b1;
    int unsigned burst_left = 0;
    int unsigned rx_seg_left = 0;
    int unsigned rx_mode     = RX_FREE;
    int unsigned rx_streak   = 0;
    logic        rx_hold;
    int unsigned idle_cycles = 0;

    ultrasonic_echo_ranger dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_echo_level         (i_echo_level),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_trigger_level      (o_trigger_level),
        .o_measure_done       (o_measure_done),
        .o_no_echo            (o_no_echo),
        .o_echo_width_us      (o_echo_width_us),
        .o_distance_tenths_cm (o_distance_tenths_cm),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    echo_ranger_checker u_ranger_check (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .i_in_stall           (o_in_stall),
        .i_echo_level         (i_echo_level),
        .i_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .i_trigger_level      (o_trigger_level),
        .i_measure_done       (o_measure_done),
        .i_no_echo            (o_no_echo),
        .i_echo_width_us      (o_echo_width_us),
        .i_distance_tenths_cm (o_distance_tenths_cm),
        .i_psel               (psel),
        .i_penable            (penable),
        .i_pwrite             (pwrite),
        .i_pready             (pready),
        .i_paddr              (paddr),
        .i_pwdata             (pwdata),
        .o_mismatches         (n_mismatches),
        .o_pending            (n_pending),
        .o_ticks              (n_ticks),
        .o_measures           (n_measures),
        .o_misses             (n_misses),
        .o_widest             (n_widest)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: segments of no stall, light stall and heavy stall, streaks capped
    always @(posedge i_clk) begin
        if (rx_seg_left == 0) begin
            rx_mode     = $urandom_range(RX_FREE, RX_HEAVY);
            rx_seg_left = $urandom_range(16, 160);
        end
        rx_seg_left--;
        case (rx_mode)
            RX_FREE:   rx_hold = 1'b0;
            RX_CHOPPY: rx_hold = ($urandom_range(0, 3) == 0);
            default:   rx_hold = ($urandom_range(0, 2) != 0);
        endcase
        if (rx_streak >= 8)
            rx_hold = 1'b0;
        rx_streak = rx_hold ? rx_streak + 1 : 0;
        i_out_stall <= rx_hold;
    end

    // Abandon the run once neither channel has moved a word for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WD_LIMIT) begin
                $display("tb_ultrasonic_echo_ranger: errors");
                $finish;
            end
        end
    end

    // Offer one tick word, with a random gap between bursts while pacing
    task automatic push_tick(input logic lvl);
        if (pacing && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid   <= 1'b1;
        i_echo_level <= lvl;
        do @(posedge i_clk); while (o_in_stall);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Drop valid and hold until every outstanding result word has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (n_pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // One random setting, then echo pulse trains mixed with noise
    task automatic random_phase(input int unsigned n_words);
        int unsigned trig_v;
        int unsigned tmo_v;
        int unsigned pause_v;
        int unsigned sent;
        int unsigned lo_run;
        int unsigned hi_run;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        trig_v = (pick == 0) ? 0 : (pick < 7) ? $urandom_range(1, 5) : $urandom_range(6, 40);
        pick = $urandom_range(0, 9);
        tmo_v = (pick == 0) ? 0 : (pick < 6) ? $urandom_range(1, 30) : $urandom_range(31, 300);
        pick = $urandom_range(0, 9);
        pause_v = (pick < 3) ? 0 : (pick < 8) ? $urandom_range(1, 8) : $urandom_range(9, 80);
        settle();
        cfg_write(REG_PAUSE, DATA_W'(pause_v));
        cfg_write(REG_TRIGGER, DATA_W'(trig_v));
        cfg_write(REG_TIMEOUT, DATA_W'(tmo_v));
        if ($urandom_range(0, 3) == 0)
            cfg_write(REG_UNMAPPED, DATA_W'($urandom));
        pacing = ($urandom_range(0, 3) != 0);
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(0, 4) == 0) begin
                push_tick(1'($urandom_range(0, 1)));
                sent++;
            end else begin
                lo_run = $urandom_range(0, 12);
                hi_run = $urandom_range(1, tmo_v + 4);
                repeat (lo_run) push_tick(1'b0);
                repeat (hi_run) push_tick(1'b1);
                sent += lo_run + hi_run;
            end
        end
    endtask

    initial begin : stimulus
        int unsigned p;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: ten trigger ticks, short wait, three-tick echo
        repeat (12) push_tick(1'b0);
        repeat (3) push_tick(1'b1);
        push_tick(1'b0);

        // Zero trigger, zero timeout, zero pause: timeouts on waiting low and high
        settle();
        cfg_write(REG_TRIGGER, '0);
        cfg_write(REG_TIMEOUT, '0);
        cfg_write(REG_PAUSE, '0);
        repeat (4) push_tick(1'b0);
        push_tick(1'b1);

        // One-tick trigger, widest pause, unmapped write ignored
        settle();
        cfg_write(REG_TRIGGER, DATA_W'(1));
        cfg_write(REG_TIMEOUT, DATA_W'(65534));
        cfg_write(REG_PAUSE, DATA_W'(65535));
        cfg_write(REG_UNMAPPED, '1);
        push_tick(1'b0);
        push_tick(1'b0);
        push_tick(1'b1);
        push_tick(1'b0);

        for (p = 0; p < 6; p++)
            random_phase(210);

        // Longer trigger, then a long echo under the widest timeout
        settle();
        pacing = 1'b0;
        cfg_write(REG_PAUSE, '0);
        cfg_write(REG_TIMEOUT, DATA_W'(65535));
        cfg_write(REG_TRIGGER, DATA_W'(40));
        repeat (50) push_tick(1'b0);
        repeat (150) push_tick(1'b1);
        repeat (4) push_tick(1'b0);

        settle();
        $display("run covered %0d tick words and %0d finished measurements (%0d with no echo)",
                 n_ticks, n_measures, n_misses);
        $display("widest echo seen %0d us", n_widest);
        if (n_mismatches == 0 && n_pending == 0)
            $display("tb_ultrasonic_echo_ranger: clean");
        else
            $display("tb_ultrasonic_echo_ranger: errors");
        $finish;
    end

endmodule
